>>> sv/lsbse_pkg.sv
// ----------------------------------------------------------------------------
// lsbse_pkg
// Shared types and codes for the LSB steganography embed/extract block.
// ----------------------------------------------------------------------------
package lsbse_pkg;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_MODE      = 2'd0;
	localparam logic [1:0] REG_DIRECTION = 2'd1;
	localparam logic [1:0] REG_ENCRYPTED = 2'd2;

	// Embedding modes
	localparam logic [1:0] MODE_LSB1 = 2'd0;
	localparam logic [1:0] MODE_LSB4 = 2'd1;
	localparam logic [1:0] MODE_LSBE = 2'd2;

	// Direction codes
	localparam logic DIR_EMBED   = 1'b0;
	localparam logic DIR_EXTRACT = 1'b1;

	// Input item kinds
	localparam logic FUNC_MESSAGE   = 1'b0;
	localparam logic FUNC_COMPONENT = 1'b1;

	// Result kinds
	localparam logic [1:0] KIND_COMPONENT = 2'd0;
	localparam logic [1:0] KIND_SIZE      = 2'd1;
	localparam logic [1:0] KIND_PAYLOAD   = 2'd2;
	localparam logic [1:0] KIND_EXTENSION = 2'd3;

	// Extraction phases
	localparam logic [1:0] PHASE_SIZE      = 2'd0;
	localparam logic [1:0] PHASE_PAYLOAD   = 2'd1;
	localparam logic [1:0] PHASE_EXTENSION = 2'd2;
	localparam logic [1:0] PHASE_DONE      = 2'd3;

	// Component values that carry a bit in LSBE mode
	localparam logic [7:0] LSBE_LOW  = 8'hFE;
	localparam logic [7:0] LSBE_HIGH = 8'hFF;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;
	localparam logic [2:0] SIZE_BYTES    = 3'd4;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef struct packed {
		logic       func;
		logic [7:0] data;
	} req_t;

	typedef struct packed {
		logic [7:0] out_value;
		logic [1:0] out_kind;
		logic       is_last;
		logic       carried_bits;
		logic       message_empty;
	} rsp_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       direction;
		logic       encrypted;
	} cfg_t;

endpackage

>>> sv/lsbse_cfg.sv
// ----------------------------------------------------------------------------
// lsbse_cfg
// APB register file: mode, direction and encrypted flag.
// ----------------------------------------------------------------------------
module lsbse_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lsbse_pkg::PADDR_W-1:0]   paddr,
	input  logic [lsbse_pkg::PDATA_W-1:0]   pwdata,
	output logic [lsbse_pkg::PDATA_W-1:0]   prdata,
	output logic                            pready,
	output lsbse_pkg::cfg_t                 cfg
);
	import lsbse_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	// Write the addressed register; drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MODE:      cfg_q.mode      <= pwdata[1:0];
				REG_DIRECTION: cfg_q.direction <= pwdata[0];
				REG_ENCRYPTED: cfg_q.encrypted <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_MODE:      prdata[1:0] = cfg_q.mode;
			REG_DIRECTION: prdata[0]   = cfg_q.direction;
			REG_ENCRYPTED: prdata[0]   = cfg_q.encrypted;
			default:       prdata      = '0;
		endcase
	end

endmodule

>>> sv/lsbse_core.sv
// ----------------------------------------------------------------------------
// lsbse_core
// Input register, embed/extract step logic with message state, and result
// register.
// ----------------------------------------------------------------------------
module lsbse_core (
	input  logic            clk,
	input  logic            arst_n,
	input  lsbse_pkg::cfg_t cfg,
	input  logic            req_valid,
	output logic            req_stall,
	input  lsbse_pkg::req_t req_item,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output lsbse_pkg::rsp_t rsp_item
);
	import lsbse_pkg::*;

	// Pipeline and result registers
	logic        valid_s1;
	req_t        item_s1;
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	// Message state
	logic [7:0]  held_byte_q,      held_byte_d;
	logic [3:0]  held_bits_left_q, held_bits_left_d;
	logic [7:0]  gather_byte_q,    gather_byte_d;
	logic [3:0]  gather_count_q,   gather_count_d;
	logic [2:0]  header_count_q,   header_count_d;
	logic [31:0] payload_size_q,   payload_size_d;
	logic [31:0] payload_count_q,  payload_count_d;
	logic [1:0]  extract_phase_q,  extract_phase_d;

	logic        advance;
	logic        res_valid;
	rsp_t        res;
	logic [3:0]  k;
	logic        usable;
	logic [3:0]  n;
	logic [7:0]  emb_mask;
	logic [7:0]  ext_mask;
	logic [3:0]  shift;
	logic [7:0]  bits;
	logic [3:0]  count_sum;

	assign advance   = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	// Per-component bit count and LSBE usability
	assign k        = (cfg.mode == MODE_LSB4) ? 4'd4 : 4'd1;
	assign usable   = (cfg.mode != MODE_LSBE) ||
	                  (item_s1.data == LSBE_LOW) || (item_s1.data == LSBE_HIGH);
	assign n        = (held_bits_left_q < k) ? held_bits_left_q : k;
	assign emb_mask = (8'd1 << n) - 8'd1;
	assign ext_mask = (8'd1 << k) - 8'd1;
	assign shift    = held_bits_left_q - n;
	assign bits     = (held_byte_q >> shift) & emb_mask;
	assign count_sum = gather_count_q + k;

	// Work out the result and the next state for the item in stage one
	always_comb begin
		held_byte_d      = held_byte_q;
		held_bits_left_d = held_bits_left_q;
		gather_byte_d    = gather_byte_q;
		gather_count_d   = gather_count_q;
		header_count_d   = header_count_q;
		payload_size_d   = payload_size_q;
		payload_count_d  = payload_count_q;
		extract_phase_d  = extract_phase_q;
		res_valid        = 1'b0;
		res              = '0;

		if (item_s1.func == FUNC_MESSAGE) begin
			if (cfg.direction == DIR_EMBED) begin
				held_byte_d      = item_s1.data;
				held_bits_left_d = BITS_PER_BYTE;
			end
		end else if (cfg.direction == DIR_EMBED) begin
			res_valid           = 1'b1;
			res.out_kind        = KIND_COMPONENT;
			res.out_value       = item_s1.data;
			if ((held_bits_left_q != 4'd0) && usable) begin
				res.out_value    = (item_s1.data & ~emb_mask) | bits;
				res.carried_bits = 1'b1;
				held_bits_left_d = held_bits_left_q - n;
			end
			res.message_empty   = (held_bits_left_d == 4'd0);
		end else if ((extract_phase_q != PHASE_DONE) && usable) begin
			gather_byte_d  = (gather_byte_q << k) | (item_s1.data & ext_mask);
			gather_count_d = count_sum;
			if (count_sum >= BITS_PER_BYTE) begin
				gather_count_d = 4'd0;
				res_valid      = 1'b1;
				res.out_value  = gather_byte_d;
				case (extract_phase_q)
					PHASE_SIZE: begin
						res.out_kind   = KIND_SIZE;
						payload_size_d = {payload_size_q[23:0], gather_byte_d};
						header_count_d = header_count_q + 3'd1;
						if (header_count_d >= SIZE_BYTES) begin
							payload_count_d = '0;
							if (payload_size_d != 32'd0) begin
								extract_phase_d = PHASE_PAYLOAD;
							end else if (cfg.encrypted) begin
								extract_phase_d = PHASE_DONE;
								res.is_last     = 1'b1;
							end else begin
								extract_phase_d = PHASE_EXTENSION;
							end
						end
					end
					PHASE_PAYLOAD: begin
						res.out_kind    = KIND_PAYLOAD;
						payload_count_d = payload_count_q + 32'd1;
						if (payload_count_d == payload_size_q) begin
							if (cfg.encrypted) begin
								extract_phase_d = PHASE_DONE;
								res.is_last     = 1'b1;
							end else begin
								extract_phase_d = PHASE_EXTENSION;
							end
						end
					end
					default: begin
						res.out_kind = KIND_EXTENSION;
						if (gather_byte_d == 8'd0) begin
							extract_phase_d = PHASE_DONE;
							res.is_last     = 1'b1;
						end
					end
				endcase
			end
		end
	end

	// Capture the incoming request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			item_s1 <= req_item;
		end
	end

	// Load the result register and commit state as stage one drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q      <= 1'b0;
			held_byte_q      <= '0;
			held_bits_left_q <= '0;
			gather_byte_q    <= '0;
			gather_count_q   <= '0;
			header_count_q   <= '0;
			payload_size_q   <= '0;
			payload_count_q  <= '0;
			extract_phase_q  <= PHASE_SIZE;
		end else if (advance) begin
			rsp_valid_q <= valid_s1 && res_valid;
			if (valid_s1) begin
				held_byte_q      <= held_byte_d;
				held_bits_left_q <= held_bits_left_d;
				gather_byte_q    <= gather_byte_d;
				gather_count_q   <= gather_count_d;
				header_count_q   <= header_count_d;
				payload_size_q   <= payload_size_d;
				payload_count_q  <= payload_count_d;
				extract_phase_q  <= extract_phase_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid) begin
			rsp_q <= res;
		end
	end

	// Held bits never exceed one byte
	a_held_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_bits_left_q <= BITS_PER_BYTE)
		else $error("held bit count above one byte");

	// A completed byte always restarts the gather count
	a_gather_range: assert property (@(posedge clk) disable iff (!arst_n)
		gather_count_q < BITS_PER_BYTE)
		else $error("gather count not restarted");

	// Recovered bytes carry no embedding flags
	a_extract_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (rsp_q.out_kind != KIND_COMPONENT) |->
			!rsp_q.carried_bits && !rsp_q.message_empty)
		else $error("embedding flags on recovered byte");

	// The last recovered byte leaves extraction finished
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.is_last |-> extract_phase_q == PHASE_DONE)
		else $error("last byte without finished extraction");

endmodule

>>> sv/lsb_stego_embed_extract.sv
// ----------------------------------------------------------------------------
// lsb_stego_embed_extract
// LSB steganography: hides message bits in carrier colour components, or
// recovers size, payload and extension bytes from them.
// ----------------------------------------------------------------------------
//  channel   handshake              payload    direction
//  request   req_valid / req_stall  req_item   into block
//  result    rsp_valid / rsp_stall  rsp_item   out of block
//  config    psel/penable/pwrite    paddr etc  APB slave
//
//  One request per cycle while req_stall is low; a taken request is held in
//  the input register, and the result register takes its result from there
//  once that register is free or its result is being taken.
//  Message bytes give no result; in extraction only a completed byte does.
//  A stalled result holds in the result register while one more request
//  waits in the input register; after that req_stall rises.
//  arst_n clears registers, message state and extraction progress.
// ----------------------------------------------------------------------------
module lsb_stego_embed_extract (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  lsbse_pkg::req_t                 req_item,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output lsbse_pkg::rsp_t                 rsp_item,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lsbse_pkg::PADDR_W-1:0]   paddr,
	input  logic [lsbse_pkg::PDATA_W-1:0]   pwdata,
	output logic [lsbse_pkg::PDATA_W-1:0]   prdata,
	output logic                            pready
);
	import lsbse_pkg::*;

	cfg_t cfg;

	// Register file
	lsbse_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Embed/extract datapath
	lsbse_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

endmodule

>>> dv/lsb_stego_embed_extract_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsb_stego_embed_extract_chk
// Watches the request, result and configuration channels of the LSB
// steganography block. Keeps its own copy of the registers and the embed and
// extract state, works out the result of every accepted request and compares
// each accepted result with the oldest one still awaited.
// ----------------------------------------------------------------------------
module lsb_stego_embed_extract_chk (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic                          req_stall,
	input  lsbse_pkg::req_t               req_item,
	input  logic                          rsp_valid,
	input  logic                          rsp_stall,
	input  lsbse_pkg::rsp_t               rsp_item,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lsbse_pkg::PADDR_W-1:0] paddr,
	input  logic [lsbse_pkg::PDATA_W-1:0] pwdata,
	input  logic                          pready,
	output int                            errors,
	output int                            pending
);
	import lsbse_pkg::*;

	cfg_t        regs = '0;
	logic [7:0]  held_byte = '0;
	logic [3:0]  held_left = '0;
	logic [7:0]  gather = '0;
	logic [3:0]  gather_cnt = '0;
	logic [2:0]  hdr_cnt = '0;
	logic [31:0] pay_size = '0;
	logic [31:0] pay_cnt = '0;
	logic [1:0]  xphase = PHASE_SIZE;
	rsp_t        stego_out_q[$];
	int          mismatch_cnt = 0;

	// Work out what one accepted request gives, and queue it
	task automatic stego_step(input req_t r);
		int         k;
		int         n;
		logic [7:0] mask;
		logic       usable;
		logic       last;
		logic [1:0] kind;
		rsp_t       res;
		k = (regs.mode == MODE_LSB4) ? 4 : 1;
		usable = (regs.mode != MODE_LSBE) || r.data == LSBE_LOW || r.data == LSBE_HIGH;
		res = '0;

		// a message byte only matters when embedding, and replaces held bits
		if (r.func == FUNC_MESSAGE) begin
			if (regs.direction == DIR_EMBED) begin
				held_byte = r.data;
				held_left = BITS_PER_BYTE;
			end
			return;
		end

		// embed: overwrite up to k low bits, fewer if fewer are held
		if (regs.direction == DIR_EMBED) begin
			res.out_value = r.data;
			if (held_left != 4'd0 && usable) begin
				n = (held_left < k) ? int'(held_left) : k;
				mask = 8'((1 << n) - 1);
				res.out_value = (r.data & ~mask) |
					(8'(held_byte >> (int'(held_left) - n)) & mask);
				held_left = 4'(int'(held_left) - n);
				res.carried_bits = 1'b1;
			end
			res.out_kind = KIND_COMPONENT;
			res.message_empty = (held_left == 4'd0);
			stego_out_q.push_back(res);
			return;
		end

		// extract: skip when finished or the component carries nothing
		if (xphase == PHASE_DONE || !usable)
			return;
		gather = (k == 4) ? {gather[3:0], r.data[3:0]} : {gather[6:0], r.data[0]};
		gather_cnt = gather_cnt + 4'(k);
		if (gather_cnt < BITS_PER_BYTE)
			return;
		gather_cnt = '0;

		last = 1'b0;
		case (xphase)
		PHASE_SIZE: begin
			kind = KIND_SIZE;
			pay_size = {pay_size[23:0], gather};
			hdr_cnt = hdr_cnt + 3'd1;
			if (hdr_cnt >= SIZE_BYTES) begin
				pay_cnt = '0;
				if (pay_size == 32'd0) begin
					if (regs.encrypted) begin
						xphase = PHASE_DONE;
						last = 1'b1;
					end else begin
						xphase = PHASE_EXTENSION;
					end
				end else begin
					xphase = PHASE_PAYLOAD;
				end
			end
		end
		PHASE_PAYLOAD: begin
			kind = KIND_PAYLOAD;
			pay_cnt = pay_cnt + 32'd1;
			if (pay_cnt == pay_size) begin
				if (regs.encrypted) begin
					xphase = PHASE_DONE;
					last = 1'b1;
				end else begin
					xphase = PHASE_EXTENSION;
				end
			end
		end
		default: begin
			kind = KIND_EXTENSION;
			if (gather == 8'h00) begin
				xphase = PHASE_DONE;
				last = 1'b1;
			end
		end
		endcase
		res.out_value = gather;
		res.out_kind = kind;
		res.is_last = last;
		stego_out_q.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '0;
			held_byte = '0;
			held_left = '0;
			gather = '0;
			gather_cnt = '0;
			hdr_cnt = '0;
			pay_size = '0;
			pay_cnt = '0;
			xphase = PHASE_SIZE;
			stego_out_q.delete();
			mismatch_cnt = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			// compare the result taken at this edge with the oldest awaited one
			if (rsp_valid && !rsp_stall) begin
				if (stego_out_q.size() == 0) begin
					$display({"%0t: unexpected result: expected none, ",
						"got value=%02h kind=%0d last=%0b carried=%0b empty=%0b"},
						$time, rsp_item.out_value, rsp_item.out_kind, rsp_item.is_last,
						rsp_item.carried_bits, rsp_item.message_empty);
					mismatch_cnt++;
				end else begin
					if (rsp_item !== stego_out_q[0]) begin
						$display({"%0t: result mismatch: expected value=%02h kind=%0d ",
							"last=%0b carried=%0b empty=%0b, got value=%02h kind=%0d ",
							"last=%0b carried=%0b empty=%0b"},
							$time, stego_out_q[0].out_value, stego_out_q[0].out_kind,
							stego_out_q[0].is_last, stego_out_q[0].carried_bits,
							stego_out_q[0].message_empty, rsp_item.out_value,
							rsp_item.out_kind, rsp_item.is_last, rsp_item.carried_bits,
							rsp_item.message_empty);
						mismatch_cnt++;
					end
					void'(stego_out_q.pop_front());
				end
			end

			// follow register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
				REG_MODE:      regs.mode = pwdata[1:0];
				REG_DIRECTION: regs.direction = pwdata[0];
				REG_ENCRYPTED: regs.encrypted = pwdata[0];
				default: ;
				endcase
			end

			// predict the accepted request
			if (req_valid && !req_stall)
				stego_step(req_item);

			pending <= stego_out_q.size();
			errors <= mismatch_cnt;
		end
	end

endmodule

>>> dv/lsb_stego_embed_extract_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsb_stego_embed_extract_tb
// Drives message bytes and carrier components into the LSB steganography
// block under every mode and direction. A short directed run covers the
// embedding corner cases; the random run mixes embedding with the recovery of
// one well-formed hidden message, with noise, under varied idling and stalls.
// ----------------------------------------------------------------------------
module lsb_stego_embed_extract_tb;
	import lsbse_pkg::*;

	localparam int         RANDOM_ITEMS = 1250;
	localparam logic [1:0] MODE_SPARE   = 2'd3;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	req_t               req_item = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	rsp_t               rsp_item;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int                 errors;
	int                 pending;

	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         counted = 0;
	logic [1:0] cur_mode = MODE_LSB1;
	logic       hidden_bits[$];
	int         hidden_len;
	logic [31:0] msg_size;

	lsb_stego_embed_extract uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	lsb_stego_embed_extract_chk chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// stall the result side at random
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// hard stop
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
		0: return 8'h00;
		1: return 8'hFF;
		default: return 8'($urandom);
		endcase
	endfunction

	task automatic queue_byte(input logic [7:0] b);
		for (int i = 7; i >= 0; i--)
			hidden_bits.push_back(b[i]);
	endtask

	// Offer one request, idling first at random, and return at its acceptance
	task automatic send(input logic f, input logic [7:0] d);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_item <= '{func: f, data: d};
		do @(posedge clk); while (req_stall);
	endtask

	// Drop valid and wait until every awaited result has come out
	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [1:0] m, input logic dir, input logic enc);
		settle();
		apb_write(REG_MODE, PDATA_W'(m));
		apb_write(REG_DIRECTION, PDATA_W'(dir));
		apb_write(REG_ENCRYPTED, PDATA_W'(enc));
		cur_mode = m;
	endtask

	// Send components that carry n hidden bits in the current mode, with noise
	task automatic hide_bits(input int n);
		int         k;
		int         taken;
		int         j;
		logic [3:0] nib;
		logic [7:0] d;
		k = (cur_mode == MODE_LSB4) ? 4 : 1;
		taken = 0;
		while (taken < n) begin
			if ($urandom_range(9) == 0)
				send(FUNC_MESSAGE, pick_byte());
			if (cur_mode == MODE_LSBE && $urandom_range(1))
				send(FUNC_COMPONENT, 8'($urandom_range(253)));
			nib = 4'($urandom);
			for (j = k - 1; j >= 0; j--) begin
				if (hidden_bits.size() != 0)
					nib[j] = hidden_bits.pop_front();
			end
			case (cur_mode)
			MODE_LSB4: d = {4'($urandom), nib};
			MODE_LSBE: d = {7'h7F, nib[0]};
			default:   d = {7'($urandom), nib[0]};
			endcase
			send(FUNC_COMPONENT, d);
			taken += k;
			counted++;
		end
	endtask

	initial begin
		int   phase_no;
		int   bits_used;
		logic split_done;
		logic extract;
		logic enc;
		logic [1:0] m;

		// build the one message to recover: size, payload, extension, NUL, spare
		msg_size = ($urandom_range(4) == 0) ? 32'd0 : 32'($urandom_range(1, 24));
		queue_byte(msg_size[31:24]);
		queue_byte(msg_size[23:16]);
		queue_byte(msg_size[15:8]);
		queue_byte(msg_size[7:0]);
		repeat (msg_size) queue_byte(pick_byte());
		repeat ($urandom_range(5)) queue_byte(8'($urandom_range(1, 255)));
		queue_byte(8'h00);
		queue_byte(pick_byte());
		queue_byte(pick_byte());
		hidden_len = hidden_bits.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single-bit embedding, nothing held, replacement of held bits
		configure(MODE_LSB1, DIR_EMBED, 1'b0);
		send(FUNC_COMPONENT, 8'hAB);
		send(FUNC_MESSAGE, 8'hFF);
		send(FUNC_COMPONENT, 8'h00);
		send(FUNC_MESSAGE, 8'h80);
		send(FUNC_COMPONENT, 8'h00);
		send(FUNC_COMPONENT, 8'hFF);
		send(FUNC_COMPONENT, 8'h55);
		send(FUNC_COMPONENT, 8'hAA);
		send(FUNC_COMPONENT, 8'h01);
		send(FUNC_COMPONENT, 8'hFE);
		// two bits left when four are taken
		configure(MODE_LSB4, DIR_EMBED, 1'b1);
		send(FUNC_COMPONENT, 8'h00);
		send(FUNC_COMPONENT, 8'h77);
		send(FUNC_MESSAGE, 8'hA5);
		send(FUNC_COMPONENT, 8'hFF);
		send(FUNC_COMPONENT, 8'h00);
		// only 0xFE and 0xFF carry a bit
		configure(MODE_LSBE, DIR_EMBED, 1'b0);
		send(FUNC_MESSAGE, 8'h3C);
		send(FUNC_COMPONENT, 8'h12);
		send(FUNC_COMPONENT, 8'hFE);
		send(FUNC_COMPONENT, 8'hFF);
		send(FUNC_COMPONENT, 8'h7F);
		// spare mode acts as single-bit
		configure(MODE_SPARE, DIR_EMBED, 1'b0);
		send(FUNC_MESSAGE, 8'hC3);
		send(FUNC_COMPONENT, 8'h80);

		// random phases
		phase_no = 0;
		split_done = 1'b0;
		while (counted < RANDOM_ITEMS) begin
			m = (phase_no < 4) ? 2'(phase_no) : 2'($urandom_range(3));
			if (hidden_bits.size() != 0)
				extract = 1'($urandom_range(1));
			else
				extract = ($urandom_range(7) == 0);
			enc = 1'($urandom_range(1));
			configure(m, extract ? DIR_EXTRACT : DIR_EMBED, enc);

			// vary idling per phase, with some phases left clean
			case (phase_no % 4)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 75;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 75;
			end
			default: begin
				send_idle_pct = 21;
				recv_stall_pct = 21;
			end
			endcase

			bits_used = hidden_len - hidden_bits.size();
			if (extract && !split_done && cur_mode == MODE_LSB1 && bits_used >= 32 &&
			    bits_used + 8 <= 32 + 8 * int'(msg_size)) begin
				// split one payload byte across a mode change so the gather overflows
				hide_bits(6);
				configure(MODE_LSB4, DIR_EXTRACT, enc);
				send(FUNC_COMPONENT, pick_byte());
				void'(hidden_bits.pop_front());
				void'(hidden_bits.pop_front());
				split_done = 1'b1;
			end else if (extract) begin
				hide_bits(8 * $urandom_range(1, 4));
			end else begin
				repeat ($urandom_range(10, 50)) begin
					if ($urandom_range(3) == 0)
						send(FUNC_MESSAGE, pick_byte());
					else if (cur_mode == MODE_LSBE && $urandom_range(1))
						send(FUNC_COMPONENT, $urandom_range(1) ? LSBE_HIGH : LSBE_LOW);
					else
						send(FUNC_COMPONENT, pick_byte());
					counted++;
				end
			end
			phase_no++;
		end

		settle();
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
